// File: hdl/agsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package agsq_pkg;

    // shared datapath operations
    typedef logic [1:0] t_op;
    localparam t_op OP_MUL  = 2'd0;
    localparam t_op OP_SQRT = 2'd1;
    localparam t_op OP_DIV  = 2'd2;

    // configuration register indexes
    typedef logic [2:0] t_reg;
    localparam t_reg REG_GM       = 3'd0;
    localparam t_reg REG_RADIUS   = 3'd1;
    localparam t_reg REG_ASC_END  = 3'd2;
    localparam t_reg REG_PO_END   = 3'd3;
    localparam t_reg REG_PO_ANGLE = 3'd4;
    localparam t_reg REG_APO_GOAL = 3'd5;
    localparam t_reg REG_PER_GOAL = 3'd6;

    // flight phases and orbit-raising sub-phases
    typedef logic [2:0] t_mode;
    localparam t_mode PH_ASCENT    = 3'd1;
    localparam t_mode PH_PITCHOVER = 3'd2;
    localparam t_mode PH_RAISE     = 3'd3;
    localparam t_mode PH_COAST     = 3'd4;
    localparam t_mode SUB_NONE     = 3'd0;
    localparam t_mode SUB_BURN1    = 3'd1;
    localparam t_mode SUB_COAST    = 3'd2;
    localparam t_mode SUB_BURN2    = 3'd3;
    localparam t_mode SUB_DONE     = 3'd4;

    localparam logic signed [18:0] VERTICAL_PITCH = 19'sd102944;
    localparam logic signed [43:0] COAST_MARGIN   = 44'sd500;
    localparam logic signed [43:0] CAP_SIGNED     = 44'sd1099511627776;
    localparam logic [40:0]        CAP_MAG        = 41'h100_0000_0000;
    localparam logic [127:0]       MEGA           = 128'd1000000;

    function automatic logic [30:0] mag31(input logic [30:0] v);
        mag31 = v[30] ? (31'd0 - v) : v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [43:0] v);
        if (v > 44'sd2147483647) begin
            sat32 = 32'h7FFF_FFFF;
        end else if (v < -44'sd2147483648) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: hdl/ascent_guidance_sequencer.sv
// Ascent guidance sequencer.
// Input channel (i_in_valid / o_in_ready) takes one state word per guidance tick:
// position (m), velocity (mm/s) and flight path angle. Output channel
// (o_out_valid / i_out_ready) returns one word per tick: pitch command, thrust
// flag, phase, sub-phase and the altitude, apoapsis and periapsis altitudes.
// The configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
// one register per word by index; write only while no tick is in flight.
// One tick is worked through a 32-step microsequence on a single shared
// 256-bit add/subtract unit: bit-serial multiplies (one multiplier bit a
// cycle), digit-serial square roots (two radicand bits a cycle) and restoring
// divides (one quotient bit a cycle). The time a tick takes depends on
// operand sizes; one tick is in flight at a time and a new tick can be
// taken in the cycle after the previous result is loaded.
// o_in_ready is high only while the sequencer is idle. A finished word waits
// in the output register; a new tick may be taken while it waits, and the next
// result is held back until the receiver takes the previous one.
// Reset returns phase to vertical ascent, sub-phase and held pitch to zero,
// and all configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module ascent_guidance_sequencer
    import agsq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [30:0] i_pos_x,
    input  wire logic signed [30:0] i_pos_y,
    input  wire logic signed [30:0] i_pos_z,
    input  wire logic signed [30:0] i_vel_x,
    input  wire logic signed [30:0] i_vel_y,
    input  wire logic signed [30:0] i_vel_z,
    input  wire logic signed [18:0] i_path_angle,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [18:0]      o_pitch_cmd,
    output logic                    o_thrust_on,
    output logic [2:0]              o_phase,
    output logic [2:0]              o_sub_phase,
    output logic signed [31:0]      o_altitude_out,
    output logic signed [31:0]      o_apoapsis_out,
    output logic signed [31:0]      o_periapsis_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [49:0]        i_cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_POST  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [4:0] LAST_STEP = 5'd31;

    // configuration
    logic [49:0]        r_gm;
    logic [25:0]        r_radius;
    logic [30:0]        r_asc_end;
    logic [30:0]        r_po_end;
    logic signed [18:0] r_po_angle;
    logic signed [31:0] r_apo_goal;
    logic signed [31:0] r_per_goal;

    // control
    logic [2:0] r_state;
    logic [4:0] r_step;
    logic [7:0] r_cnt;
    t_op        r_op;
    logic       r_neg;
    logic       r_ovf;

    // shared unit
    logic [255:0] r_acc;
    logic [255:0] r_m;
    logic [127:0] r_q;
    logic [127:0] r_d;

    // latched tick
    logic [30:0]        r_px, r_py, r_pz, r_vx, r_vy, r_vz;
    logic signed [18:0] r_fpa;

    // intermediates
    logic [30:0]  r_r0;
    logic [61:0]  r_v2;
    logic [123:0] r_h2;
    logic [69:0]  r_g6;
    logic [100:0] r_nn;
    logic         r_kneg;
    logic [92:0]  r_kmag;
    logic [201:0] r_big;
    logic [125:0] r_sum;
    logic [40:0]  r_qa;
    logic [40:0]  r_qp;

    // mode state
    logic [2:0]         r_phase;
    logic [2:0]         r_sub;
    logic signed [18:0] r_pitch;

    // output register
    logic               r_out_valid;
    logic signed [18:0] r_o_pitch;
    logic               r_o_thrust;
    logic [2:0]         r_o_phase;
    logic [2:0]         r_o_sub;
    logic [31:0]        r_o_alt;
    logic [31:0]        r_o_apo;
    logic [31:0]        r_o_peri;

    logic [255:0] w_a;
    logic [255:0] w_b;
    logic         w_sub;
    logic [255:0] w_sum;
    logic [30:0]  w_r;
    logic [40:0]  w_cap;
    logic         w_load_out;

    logic signed [43:0] w_alt;
    logic signed [43:0] w_apo;
    logic signed [43:0] w_peri;
    logic signed [43:0] w_rad;
    logic signed [43:0] w_qa;

    logic [2:0]         n_phase;
    logic [2:0]         n_sub;
    logic signed [18:0] n_pitch;
    logic               n_thrust;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_pitch_cmd = r_o_pitch;
    assign o_thrust_on = r_o_thrust;
    assign o_phase     = r_o_phase;
    assign o_sub_phase = r_o_sub;
    assign o_altitude_out  = r_o_alt;
    assign o_apoapsis_out  = r_o_apo;
    assign o_periapsis_out = r_o_peri;

    assign w_r = (r_r0 == 31'd0) ? 31'd1 : r_r0;
    assign w_load_out = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // shared add/subtract
    always_comb begin
        case (r_op)
            OP_SQRT: begin
                w_a   = {r_acc[253:0], r_m[255:254]};
                w_b   = {126'd0, r_q, 2'b01};
                w_sub = 1'b1;
            end
            OP_DIV: begin
                w_a   = {r_acc[254:0], r_m[255]};
                w_b   = {128'd0, r_d};
                w_sub = 1'b1;
            end
            default: begin
                w_a   = r_acc;
                w_b   = r_q[0] ? r_m : 256'd0;
                w_sub = r_neg;
            end
        endcase
        w_sum = w_a + (w_b ^ {256{w_sub}}) + {255'd0, w_sub};
    end

    // cap the quotient magnitude
    always_comb begin
        if (r_ovf || (r_q[127:41] != 87'd0) || (r_q[40] && (r_q[39:0] != 40'd0))) begin
            w_cap = CAP_MAG;
        end else begin
            w_cap = r_q[40:0];
        end
    end

    // altitudes and mode step
    always_comb begin
        w_rad  = $signed({18'd0, r_radius});
        w_alt  = $signed({13'd0, r_r0}) - w_rad;
        w_qa   = $signed({3'd0, r_qa});
        if (r_kmag == 93'd0) begin
            w_apo = CAP_SIGNED;
        end else begin
            w_apo = (r_kneg ? w_qa : -w_qa) - w_rad;
        end
        w_peri = $signed({3'd0, r_qp}) - w_rad;

        n_phase  = r_phase;
        n_sub    = r_sub;
        n_pitch  = r_pitch;
        n_thrust = 1'b0;
        case (r_phase)
            PH_ASCENT: begin
                n_pitch  = VERTICAL_PITCH;
                n_thrust = 1'b1;
                if (w_alt >= $signed({13'd0, r_asc_end})) n_phase = PH_PITCHOVER;
            end
            PH_PITCHOVER: begin
                n_pitch  = r_po_angle;
                n_sub    = SUB_BURN1;
                n_thrust = 1'b1;
                if (w_alt >= $signed({13'd0, r_po_end})) n_phase = PH_RAISE;
            end
            PH_RAISE: begin
                case (r_sub)
                    SUB_BURN1: begin
                        n_thrust = 1'b1;
                        if ((r_vx != 31'd0) || (r_vz != 31'd0)) n_pitch = r_fpa;
                        if (w_apo >= 44'(r_apo_goal)) n_sub = SUB_COAST;
                    end
                    SUB_COAST: begin
                        if (w_alt >= w_apo - COAST_MARGIN) n_sub = SUB_BURN2;
                    end
                    SUB_BURN2: begin
                        n_thrust = 1'b1;
                        n_pitch  = r_fpa;
                        if (w_peri >= 44'(r_per_goal)) n_sub = SUB_DONE;
                    end
                    SUB_DONE: begin
                        n_phase = PH_COAST;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gm       <= 50'd398572000000000;
            r_radius   <= 26'd6371000;
            r_asc_end  <= 31'd1000;
            r_po_end   <= 31'd10000;
            r_po_angle <= 19'sd102944;
            r_apo_goal <= 32'sd200000;
            r_per_goal <= 32'sd200000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GM:       r_gm       <= i_cfg_data;
                REG_RADIUS:   r_radius   <= i_cfg_data[25:0];
                REG_ASC_END:  r_asc_end  <= i_cfg_data[30:0];
                REG_PO_END:   r_po_end   <= i_cfg_data[30:0];
                REG_PO_ANGLE: r_po_angle <= i_cfg_data[18:0];
                REG_APO_GOAL: r_apo_goal <= i_cfg_data[31:0];
                REG_PER_GOAL: r_per_goal <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // control and mode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= 5'd0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_ASCENT;
            r_sub       <= SUB_NONE;
            r_pitch     <= 19'sd0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_step  <= 5'd0;
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: r_state <= ST_RUN;
                ST_RUN: begin
                    if (r_op == OP_MUL) begin
                        if (r_q == 128'd0) r_state <= ST_POST;
                    end else if (r_cnt == 8'd0) begin
                        r_state <= ST_POST;
                    end
                end
                ST_POST: begin
                    if (r_step == LAST_STEP) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_step  <= r_step + 5'd1;
                        r_state <= ST_SETUP;
                    end
                end
                ST_DONE: begin
                    if (w_load_out) begin
                        r_phase     <= n_phase;
                        r_sub       <= n_sub;
                        r_pitch     <= n_pitch;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_pitch  <= n_pitch;
            r_o_thrust <= n_thrust;
            r_o_phase  <= n_phase;
            r_o_sub    <= n_sub;
            r_o_alt    <= sat32(w_alt);
            r_o_apo    <= sat32(w_apo);
            r_o_peri   <= sat32(w_peri);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_px  <= i_pos_x;
                    r_py  <= i_pos_y;
                    r_pz  <= i_pos_z;
                    r_vx  <= i_vel_x;
                    r_vy  <= i_vel_y;
                    r_vz  <= i_vel_z;
                    r_fpa <= i_path_angle;
                    r_h2  <= 124'd0;
                end
            end
            ST_SETUP: begin
                r_op  <= OP_MUL;
                r_neg <= 1'b0;
                r_cnt <= 8'd0;
                r_ovf <= 1'b0;
                case (r_step)
                    5'd0: begin
                        r_acc <= 256'd0;
                        r_m   <= {225'd0, mag31(r_px)};
                        r_q   <= {97'd0, mag31(r_px)};
                    end
                    5'd1: begin
                        r_m <= {225'd0, mag31(r_py)};
                        r_q <= {97'd0, mag31(r_py)};
                    end
                    5'd2: begin
                        r_m <= {225'd0, mag31(r_pz)};
                        r_q <= {97'd0, mag31(r_pz)};
                    end
                    5'd3: begin
                        r_op  <= OP_SQRT;
                        r_m   <= {r_acc[63:0], 192'd0};
                        r_acc <= 256'd0;
                        r_q   <= 128'd0;
                        r_cnt <= 8'd31;
                    end
                    5'd4: begin
                        r_acc <= 256'd0;
                        r_m   <= {225'd0, mag31(r_vx)};
                        r_q   <= {97'd0, mag31(r_vx)};
                    end
                    5'd5: begin
                        r_m <= {225'd0, mag31(r_vy)};
                        r_q <= {97'd0, mag31(r_vy)};
                    end
                    5'd6: begin
                        r_m <= {225'd0, mag31(r_vz)};
                        r_q <= {97'd0, mag31(r_vz)};
                    end
                    5'd7: begin
                        r_acc <= 256'd0;
                        r_m   <= {225'd0, mag31(r_py)};
                        r_q   <= {97'd0, mag31(r_vz)};
                        r_neg <= r_py[30] ^ r_vz[30];
                    end
                    5'd8: begin
                        r_m   <= {225'd0, mag31(r_pz)};
                        r_q   <= {97'd0, mag31(r_vy)};
                        r_neg <= ~(r_pz[30] ^ r_vy[30]);
                    end
                    5'd11: begin
                        r_acc <= 256'd0;
                        r_m   <= {225'd0, mag31(r_pz)};
                        r_q   <= {97'd0, mag31(r_vx)};
                        r_neg <= r_pz[30] ^ r_vx[30];
                    end
                    5'd12: begin
                        r_m   <= {225'd0, mag31(r_px)};
                        r_q   <= {97'd0, mag31(r_vz)};
                        r_neg <= ~(r_px[30] ^ r_vz[30]);
                    end
                    5'd15: begin
                        r_acc <= 256'd0;
                        r_m   <= {225'd0, mag31(r_px)};
                        r_q   <= {97'd0, mag31(r_vy)};
                        r_neg <= r_px[30] ^ r_vy[30];
                    end
                    5'd16: begin
                        r_m   <= {225'd0, mag31(r_py)};
                        r_q   <= {97'd0, mag31(r_vx)};
                        r_neg <= ~(r_py[30] ^ r_vx[30]);
                    end
                    5'd9, 5'd13, 5'd17, 5'd23: begin
                        // absolute value: 0 - acc when negative
                        r_m   <= r_acc;
                        r_acc <= 256'd0;
                        r_q   <= 128'd1;
                        r_neg <= r_acc[255];
                    end
                    5'd10, 5'd14, 5'd18: begin
                        r_m   <= {194'd0, r_acc[61:0]};
                        r_q   <= {66'd0, r_acc[61:0]};
                        r_acc <= {132'd0, r_h2};
                    end
                    5'd19: begin
                        r_acc <= 256'd0;
                        r_m   <= {206'd0, r_gm};
                        r_q   <= MEGA;
                    end
                    5'd20: begin
                        r_acc <= 256'd0;
                        r_m   <= {186'd0, r_g6};
                        r_q   <= {97'd0, w_r};
                    end
                    5'd21: begin
                        r_acc <= 256'd0;
                        r_m   <= {194'd0, r_v2};
                        r_q   <= {97'd0, w_r};
                    end
                    5'd22: begin
                        r_m   <= {185'd0, r_g6, 1'b0};
                        r_q   <= 128'd1;
                        r_neg <= 1'b1;
                    end
                    5'd24: begin
                        r_acc <= 256'd0;
                        r_m   <= {155'd0, r_nn};
                        r_q   <= {27'd0, r_nn};
                    end
                    5'd25: begin
                        r_acc <= 256'd0;
                        r_m   <= {132'd0, r_h2};
                        r_q   <= {35'd0, r_kmag};
                    end
                    5'd26: begin
                        // radicand = n2 +/- kmag*h2*r
                        r_m   <= r_acc;
                        r_acc <= {54'd0, r_big};
                        r_q   <= {97'd0, w_r};
                        r_neg <= r_kneg;
                    end
                    5'd27: begin
                        r_op  <= OP_SQRT;
                        r_m   <= r_acc[255] ? 256'd0 : r_acc;
                        r_acc <= 256'd0;
                        r_q   <= 128'd0;
                        r_cnt <= 8'd127;
                    end
                    5'd28: begin
                        r_acc <= {128'd0, r_q};
                        r_m   <= {155'd0, r_nn};
                        r_q   <= 128'd1;
                    end
                    5'd29: begin
                        r_op  <= OP_DIV;
                        r_acc <= 256'd0;
                        r_m   <= {34'd0, r_sum, 96'd0};
                        r_d   <= {35'd0, r_kmag};
                        r_q   <= 128'd0;
                        r_cnt <= 8'd159;
                    end
                    5'd30: begin
                        r_acc <= 256'd0;
                        r_m   <= {132'd0, r_h2};
                        r_q   <= {97'd0, w_r};
                    end
                    default: begin
                        r_op  <= OP_DIV;
                        r_m   <= {r_acc[159:0], 96'd0};
                        r_acc <= 256'd0;
                        r_d   <= {2'd0, r_sum};
                        r_q   <= 128'd0;
                        r_cnt <= 8'd159;
                    end
                endcase
            end
            ST_RUN: begin
                case (r_op)
                    OP_SQRT: begin
                        r_acc <= w_sum[255] ? w_a : w_sum;
                        r_q   <= {r_q[126:0], ~w_sum[255]};
                        r_m   <= {r_m[253:0], 2'b00};
                        r_cnt <= r_cnt - 8'd1;
                    end
                    OP_DIV: begin
                        r_acc <= w_sum[255] ? w_a : w_sum;
                        r_q   <= {r_q[126:0], ~w_sum[255]};
                        r_ovf <= r_ovf | r_q[127];
                        r_m   <= {r_m[254:0], 1'b0};
                        r_cnt <= r_cnt - 8'd1;
                    end
                    default: begin
                        if (r_q != 128'd0) begin
                            r_acc <= w_sum;
                            r_m   <= {r_m[254:0], 1'b0};
                            r_q   <= {1'b0, r_q[127:1]};
                        end
                    end
                endcase
            end
            ST_POST: begin
                case (r_step)
                    5'd3:  r_r0   <= r_q[30:0];
                    5'd6:  r_v2   <= r_acc[61:0];
                    5'd10, 5'd14, 5'd18: r_h2 <= r_acc[123:0];
                    5'd19: r_g6   <= r_acc[69:0];
                    5'd20: r_nn   <= r_acc[100:0];
                    5'd22: r_kneg <= r_acc[255];
                    5'd23: r_kmag <= r_acc[92:0];
                    5'd24: r_big  <= r_acc[201:0];
                    5'd28: r_sum  <= r_acc[125:0];
                    5'd29: r_qa   <= w_cap;
                    5'd31: r_qp   <= w_cap;
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import agsq_pkg::*;

    typedef struct {
        logic signed [30:0] px, py, pz;
        logic signed [30:0] vx, vy, vz;
        logic signed [18:0] fpa;
    } t_tick;

    typedef struct {
        logic [18:0] pitch;
        logic        thrust;
        logic [2:0]  ph;
        logic [2:0]  sub;
        logic [31:0] alt;
        logic [31:0] apo;
        logic [31:0] peri;
    } t_guid;

    typedef struct {
        bit          is_cfg;
        t_reg        idx;
        logic [49:0] data;
        t_tick       tk;
        bit          typed;
        t_guid       want;
    } t_row;

    localparam logic [255:0] CAP_W = 256'd1 << 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [30:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [30:0] vel_x = '0, vel_y = '0, vel_z = '0;
    logic signed [18:0] path_angle = '0;
    logic               o_out_valid;
    logic               out_ready = 1'b0;
    logic signed [18:0] o_pitch_cmd;
    logic               o_thrust_on;
    logic [2:0]         o_phase, o_sub_phase;
    logic signed [31:0] o_altitude_out, o_apoapsis_out, o_periapsis_out;
    logic               cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [49:0]        cfg_data = '0;

    ascent_guidance_sequencer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_pos_x        (pos_x),
        .i_pos_y        (pos_y),
        .i_pos_z        (pos_z),
        .i_vel_x        (vel_x),
        .i_vel_y        (vel_y),
        .i_vel_z        (vel_z),
        .i_path_angle   (path_angle),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_pitch_cmd    (o_pitch_cmd),
        .o_thrust_on    (o_thrust_on),
        .o_phase        (o_phase),
        .o_sub_phase    (o_sub_phase),
        .o_altitude_out (o_altitude_out),
        .o_apoapsis_out (o_apoapsis_out),
        .o_periapsis_out(o_periapsis_out),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // shadow configuration and guidance state
    logic [255:0]       gm_s;
    logic signed [63:0] radius_s, asc_end_s, po_end_s, po_angle_s, apo_goal_s, per_goal_s;
    logic [2:0]         phase_s, sub_s;
    logic signed [63:0] pitch_s;

    t_guid guid_q[$];
    t_row  plan[$];
    int    gap_pct = 0;
    int    stall_pct = 0;
    int    n_err = 0;
    int    n_ticks = 0;
    int    n_writes = 0;
    int    n_batch = 0;
    bit [7:0] phases_seen = '0;
    bit [7:0] subs_seen = '0;

    function automatic logic [255:0] isqrt(input logic [255:0] n);
        logic [255:0] root, c;
        root = '0;
        for (int i = 127; i >= 0; i--) begin
            c = root | (256'd1 << i);
            if (c * c <= n) root = c;
        end
        return root;
    endfunction

    function automatic logic [255:0] cap40(input logic [255:0] v);
        return (v > CAP_W) ? CAP_W : v;
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    task automatic guidance_step(input t_tick t, output t_guid g);
        logic signed [63:0] px, py, pz, vx, vy, vz, alt, apo, peri;
        logic [255:0] r2, v2, cx, cy, cz, h2, r0, r, nn, ka, kb, kmag, t2, n2, rad, dd, sum, q;
        logic [255:0] mega, twomega, rad_w;
        bit kneg, thrust;
        px = t.px; py = t.py; pz = t.pz;
        vx = t.vx; vy = t.vy; vz = t.vz;
        mega = 256'd1000000;
        twomega = 256'd2000000;
        rad_w = 256'(radius_s);
        r2 = 256'(abs64(px) * abs64(px)) + 256'(abs64(py) * abs64(py))
             + 256'(abs64(pz) * abs64(pz));
        v2 = 256'(abs64(vx) * abs64(vx)) + 256'(abs64(vy) * abs64(vy))
             + 256'(abs64(vz) * abs64(vz));
        cx = 256'(abs64(py * vz - pz * vy));
        cy = 256'(abs64(pz * vx - px * vz));
        cz = 256'(abs64(px * vy - py * vx));
        h2 = cx * cx + cy * cy + cz * cz;
        r0 = isqrt(r2);
        r = (r0 == 0) ? 256'd1 : r0;
        alt = $signed(r0[63:0]) - radius_s;
        nn = mega * gm_s * r;
        ka = r * v2;
        kb = twomega * gm_s;
        kneg = ka < kb;
        kmag = kneg ? kb - ka : ka - kb;
        t2 = kmag * h2 * r;
        n2 = nn * nn;
        if (!kneg) rad = n2 + t2;
        else if (t2 >= n2) rad = '0;
        else rad = n2 - t2;
        dd = isqrt(rad);
        sum = nn + dd;
        // zero energy: apoapsis runs away to the cap
        if (kmag == 0) begin
            apo = $signed(CAP_W[63:0]);
        end else begin
            q = cap40(sum / kmag);
            apo = (kneg ? $signed(q[63:0]) : -$signed(q[63:0])) - radius_s;
        end
        q = cap40((h2 * r) / sum);
        peri = $signed(q[63:0]) - radius_s;

        thrust = 1'b0;
        case (phase_s)
            PH_ASCENT: begin
                pitch_s = VERTICAL_PITCH;
                thrust = 1'b1;
                if (alt >= asc_end_s) phase_s = PH_PITCHOVER;
            end
            PH_PITCHOVER: begin
                pitch_s = po_angle_s;
                sub_s = SUB_BURN1;
                thrust = 1'b1;
                if (alt >= po_end_s) phase_s = PH_RAISE;
            end
            PH_RAISE: begin
                case (sub_s)
                    SUB_BURN1: begin
                        thrust = 1'b1;
                        if (vx != 0 || vz != 0) pitch_s = t.fpa;
                        if (apo >= apo_goal_s) sub_s = SUB_COAST;
                    end
                    SUB_COAST: begin
                        if (alt >= apo - 64'sd500) sub_s = SUB_BURN2;
                    end
                    SUB_BURN2: begin
                        thrust = 1'b1;
                        pitch_s = t.fpa;
                        if (peri >= per_goal_s) sub_s = SUB_DONE;
                    end
                    SUB_DONE: phase_s = PH_COAST;
                    default: ;
                endcase
            end
            default: ;
        endcase
        g.pitch = pitch_s[18:0];
        g.thrust = thrust;
        g.ph = phase_s;
        g.sub = sub_s;
        g.alt = clamp32(alt);
        g.apo = clamp32(apo);
        g.peri = clamp32(peri);
    endtask

    task automatic apply_reg(input t_reg idx, input logic [49:0] d);
        case (idx)
            REG_GM:       gm_s = 256'(d);
            REG_RADIUS:   radius_s = 64'(d[25:0]);
            REG_ASC_END:  asc_end_s = 64'(d[30:0]);
            REG_PO_END:   po_end_s = 64'(d[30:0]);
            REG_PO_ANGLE: po_angle_s = 64'($signed(d[18:0]));
            REG_APO_GOAL: apo_goal_s = 64'($signed(d[31:0]));
            REG_PER_GOAL: per_goal_s = 64'($signed(d[31:0]));
            default: ;
        endcase
    endtask

    task automatic settle;
        in_valid <= 1'b0;
        while (guid_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [49:0] d);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, d);
        n_writes++;
    endtask

    task automatic send_tick(input t_tick t, input bit typed, input t_guid want);
        t_guid g;
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        pos_x <= t.px; pos_y <= t.py; pos_z <= t.pz;
        vel_x <= t.vx; vel_y <= t.vy; vel_z <= t.vz;
        path_angle <= t.fpa;
        do @(posedge i_clk); while (!o_in_ready);
        guidance_step(t, g);
        if (typed) begin
            g.pitch = want.pitch;
            g.thrust = want.thrust;
            g.ph = want.ph;
            g.sub = want.sub;
            g.alt = want.alt;
            g.apo = want.apo;
        end
        guid_q.push_back(g);
        n_ticks++;
    endtask

    function automatic logic signed [30:0] srand(input int span);
        return 31'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic t_tick rand_tick();
        t_tick t;
        int pick;
        pick = $urandom_range(99);
        t.fpa = 19'(int'($urandom_range(0, 411774)) - 205887);
        if (pick < 55) begin
            // near the body, mostly bound orbits
            t.px = 31'(radius_s + 64'($urandom_range(0, 3000000)));
            if ($urandom_range(1)) t.px = -t.px;
            t.py = srand(200000);
            t.pz = srand(200000);
            t.vx = srand(2000000);
            t.vy = srand(9000000);
            t.vz = srand(300000);
            if ($urandom_range(9) == 0) begin
                t.vx = '0;
                t.vz = '0;
            end
        end else if (pick < 90) begin
            t.px = 31'($urandom); t.py = 31'($urandom); t.pz = 31'($urandom);
            t.vx = 31'($urandom); t.vy = 31'($urandom); t.vz = 31'($urandom);
        end else begin
            t.px = ($urandom_range(1)) ? '0 : 31'($urandom);
            t.py = ($urandom_range(1)) ? '0 : 31'($urandom);
            t.pz = '0;
            t.vx = '0;
            t.vz = '0;
            t.vy = ($urandom_range(1)) ? '0 : srand(100000);
        end
        return t;
    endfunction

    task automatic run_batch(input int n);
        t_guid none;
        none = '{default: '0};
        case (n_batch % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 48; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 48; end
            default: begin gap_pct = 19; stall_pct = 19; end
        endcase
        n_batch++;
        repeat (n) send_tick(rand_tick(), 1'b0, none);
    endtask

    task automatic chk(input string nm, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", nm, e, a);
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin
        t_guid e;
        if (i_rst_n && o_out_valid && out_ready) begin
            phases_seen[o_phase] = 1'b1;
            subs_seen[o_sub_phase] = 1'b1;
            if (guid_q.size() == 0) begin
                $error("output word with nothing expected");
                n_err++;
            end else begin
                e = guid_q.pop_front();
                chk("pitch_cmd", 32'(e.pitch), 32'(o_pitch_cmd[18:0]));
                chk("thrust_on", 32'(e.thrust), 32'(o_thrust_on));
                chk("phase", 32'(e.ph), 32'(o_phase));
                chk("sub_phase", 32'(e.sub), 32'(o_sub_phase));
                chk("altitude_out", e.alt, o_altitude_out);
                chk("apoapsis_out", e.apo, o_apoapsis_out);
                chk("periapsis_out", e.peri, o_periapsis_out);
            end
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic t_row cfg_row(input t_reg idx, input logic [49:0] d);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = d;
        return r;
    endfunction

    function automatic t_row tick_row(input logic signed [30:0] px, py, pz, vx, vy, vz,
                                      input logic signed [18:0] fpa);
        t_row r;
        r = '{default: '0};
        r.tk = '{px, py, pz, vx, vy, vz, fpa};
        return r;
    endfunction

    function automatic t_row typed_row(input t_row r, input int alt, input int apo);
        r.typed = 1'b1;
        r.want = '{VERTICAL_PITCH, 1'b1, PH_ASCENT, SUB_NONE, alt, apo, 32'd0};
        return r;
    endfunction

    initial begin
        localparam logic signed [30:0] PMAX = 31'sh3FFF_FFFF;
        localparam logic signed [30:0] PMIN = -31'sh4000_0000;
        gm_s = 256'd398572000000000;
        radius_s = 6371000;
        asc_end_s = 1000;
        po_end_s = 10000;
        po_angle_s = 102944;
        apo_goal_s = 200000;
        per_goal_s = 200000;
        phase_s = PH_ASCENT;
        sub_s = SUB_NONE;
        pitch_s = 0;

        // hold ascent so the extremes stay in vertical ascent
        plan.push_back(cfg_row(REG_ASC_END, 50'h7FFF_FFFF));
        // body centre, at rest: apoapsis radius works out to one metre
        plan.push_back(typed_row(tick_row(0, 0, 0, 0, 0, 0, 0), -6371000, -6370999));
        plan.push_back(tick_row(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 19'sd205887));
        plan.push_back(tick_row(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, -19'sd205887));
        plan.push_back(tick_row(PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, 0));
        plan.push_back(tick_row(PMIN, PMAX, 0, 0, PMIN, PMAX, -1));
        plan.push_back(tick_row(1, 0, 0, 0, 0, 0, 1));
        plan.push_back(tick_row(6571000, 0, 0, 0, 7788000, 0, 0));
        plan.push_back(tick_row(-6571000, 0, 0, 0, 9000000, 0, 0));
        plan.push_back(tick_row(0, 6671000, 0, 0, 0, 12000000, 0));
        plan.push_back(tick_row(-1, -1, -1, -1, -1, -1, -1));
        plan.push_back(cfg_row(REG_GM, 50'd1));
        // zero energy: r * v^2 equals 2e6 * gm exactly
        plan.push_back(typed_row(tick_row(1, 0, 0, 1000, 1000, 0, 0), -6370999, 32'h7FFF_FFFF));
        plan.push_back(tick_row(0, 0, 0, 1000, 1000, 0, 0));
        plan.push_back(cfg_row(REG_GM, 50'h3_FFFF_FFFF_FFFF));
        plan.push_back(cfg_row(REG_RADIUS, 50'd1));
        plan.push_back(tick_row(PMAX, PMAX, PMAX, 0, 0, 0, 0));
        plan.push_back(tick_row(6571000, 0, 0, 0, 7788000, 0, 0));
        plan.push_back(cfg_row(REG_RADIUS, 50'h3FF_FFFF));
        plan.push_back(tick_row(0, 0, 0, PMAX, 0, PMIN, 0));
        plan.push_back(tick_row(70000000, 0, 0, 0, 2000000, 0, 0));
        plan.push_back(cfg_row(REG_GM, 50'd398572000000000));
        plan.push_back(cfg_row(REG_RADIUS, 50'd6371000));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
            else send_tick(plan[i].tk, plan[i].typed, plan[i].want);
        end

        run_batch(250);
        // release ascent, hold pitch-over
        write_reg(REG_ASC_END, 50'd0);
        write_reg(REG_PO_END, 50'h7FFF_FFFF);
        write_reg(REG_PO_ANGLE, 50'(-205887));
        run_batch(250);
        write_reg(REG_PO_ANGLE, 50'd205887);
        write_reg(REG_APO_GOAL, 50'h7FFF_FFFF);
        write_reg(REG_PO_END, 50'd0);
        run_batch(300);
        // first burn ends at once; hold the second burn
        write_reg(REG_PER_GOAL, 50'h7FFF_FFFF);
        write_reg(REG_APO_GOAL, 50'h8000_0000);
        run_batch(300);
        write_reg(REG_PER_GOAL, 50'h8000_0000);
        run_batch(250);
        write_reg(REG_GM, 50'd1);
        write_reg(REG_RADIUS, 50'd1);
        run_batch(200);
        write_reg(REG_GM, 50'h3_FFFF_FFFF_FFFF);
        write_reg(REG_RADIUS, 50'h3FF_FFFF);
        run_batch(150);

        settle();
        repeat (50) @(posedge i_clk);
        $display("ran %0d guidance ticks with %0d register writes", n_ticks, n_writes);
        $display("phases seen %b, sub-phases seen %b", phases_seen, subs_seen);
        if (n_err == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("timeout waiting for the block");
        $display("status: fail");
        $finish;
    end

endmodule
